FILE: rtl/pixel_sparkle_overlay_assert.svh
// assertion macros for the sparkle overlay block
`ifndef PIXEL_SPARKLE_OVERLAY_ASSERT_SVH
`define PIXEL_SPARKLE_OVERLAY_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge out of reset
`define PSO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_sparkle_overlay: assertion failed");

// next-cycle implication
`define PSO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_sparkle_overlay: assertion failed");

`else

`define PSO_ASSERT_IMP(label, ante, cons)
`define PSO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/pso_pkg.sv
// shared constants and types of the sparkle overlay block
package pso_pkg;

    // field widths
    localparam int IDX_W    = 9;
    localparam int STEP_W   = 10;
    localparam int COLOR_W  = 8;
    localparam int DENS_W   = 7;
    localparam int DMS_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // default store depth
    localparam int MAX_PIXELS_DEF = 512;

    // generator
    localparam int SEED_W = 32;
    localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_ADD   = 32'd1013904223;
    localparam logic [SEED_W-1:0] SEED_INIT = 32'd2463534242;

    // divider datapath
    localparam int NUM_W    = 20;   // 510 * step + decay_ms
    localparam int DEN_W    = 17;   // 2 * decay_ms
    localparam int THRESH_W = 17;   // density * step
    localparam int CNT_W    = 5;
    localparam logic [DEN_W-1:0] SPAWN_MOD   = 17'd20000;
    localparam logic [NUM_W-1:0] DECAY_SCALE = 20'd510;

    // spawn remainder: 20000 = 32 * 625, quotient by 625 from a reciprocal multiply
    localparam int MOD_LO_W     = 5;
    localparam int MOD_X_W      = SEED_W - MOD_LO_W;
    localparam int MOD_RECIP_W  = 28;
    localparam int MOD_PROD_W   = MOD_X_W + MOD_RECIP_W;
    localparam int MOD_RECIP_SH = 37;
    localparam int MOD_Q_W      = 18;
    localparam int MOD_R_W      = 10;
    localparam logic [MOD_RECIP_W-1:0] MOD_RECIP = 28'd219902326;   // ceil(2^37 / 625)
    localparam logic [MOD_R_W-1:0]     MOD_ODD   = 10'd625;

    // step and density limits
    localparam logic [STEP_W-1:0] STEP_MAX     = 10'd1000;
    localparam logic [STEP_W-1:0] STEP_DEFAULT = 10'd20;
    localparam logic [DENS_W-1:0] DENS_MAX     = 7'd100;

    // register reset values
    localparam logic [DENS_W-1:0] DENS_RESET = 7'd10;
    localparam logic [DMS_W-1:0]  DMS_RESET  = 16'd400;

    localparam logic [COLOR_W-1:0] LEVEL_FULL = 8'd255;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 2'd0,
        REG_DENSITY  = 2'd1,
        REG_DECAY_MS = 2'd2
    } cfg_reg_t;

endpackage

FILE: rtl/pixel_sparkle_overlay.sv
// sparkle overlay top level: level store, generator, divider and sequencer
//
// Random white sparkles laid over a stream of RGB pixels. Each pixel index owns an
// 8-bit level in an on-chip store; every enabled item fades that level by
// round(255 * step_ms / decay_ms) (at least 1, floored at 0), advances a 32-bit
// linear congruential generator once, and sets the level to 255 when
// (seed mod 20000) < density * step_ms. Each output channel is the larger of the
// input channel and the new level. A step above 1000 ms counts as 20 ms, density
// saturates at 100 and a decay time of zero counts as 1. While disabled, items
// pass unchanged with the stored level shown and nothing is updated; an index at
// or beyond MAX_PIXELS passes unchanged with level 0. After reset the store is
// swept to zero, one entry per cycle, before the first item is taken (the
// configuration writes are taken during the sweep). One item is worked at a
// time: the next one is accepted only after the last result is registered, and a
// pass-through item skips the generator and the divider. An enabled update runs
// one shift-subtract divider that produces one bit per cycle, 20 steps for the
// decay quotient; the spawn remainder comes from a reciprocal multiply for the
// quotient by 625 and a multiply-subtract for the remainder, the low five seed
// bits passing straight through. A finished result sits in an output register,
// so a stalled consumer only holds the block once the next result is ready.
`include "pixel_sparkle_overlay_assert.svh"

module pixel_sparkle_overlay #(
    parameter int MAX_PIXELS = pso_pkg::MAX_PIXELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [pso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pso_pkg::CFG_W-1:0]    cfg_data,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pso_pkg::IDX_W-1:0]    pixel_index,
    input  logic [pso_pkg::STEP_W-1:0]   step_ms,
    input  logic [pso_pkg::COLOR_W-1:0]  red_in,
    input  logic [pso_pkg::COLOR_W-1:0]  green_in,
    input  logic [pso_pkg::COLOR_W-1:0]  blue_in,
    // result item channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pso_pkg::COLOR_W-1:0]  red_out,
    output logic [pso_pkg::COLOR_W-1:0]  green_out,
    output logic [pso_pkg::COLOR_W-1:0]  blue_out,
    output logic [pso_pkg::COLOR_W-1:0]  sparkle_level
);

    import pso_pkg::*;

    // store address width and a compare width that holds both the index and the depth
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_MOD_Q,
        ST_MOD_R,
        ST_DEC_RUN,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic                enable_reg;
    logic [DENS_W-1:0]   density_reg;
    logic [DMS_W-1:0]    decay_ms_reg;

    // item held while it is worked
    logic [AW-1:0]       addr_reg;
    logic                in_range_reg;
    logic [STEP_W-1:0]   dt_reg;
    logic [COLOR_W-1:0]  red_reg;
    logic [COLOR_W-1:0]  green_reg;
    logic [COLOR_W-1:0]  blue_reg;
    logic                pass_reg;
    logic [COLOR_W-1:0]  level_reg;

    // generator and divider
    logic [SEED_W-1:0]   seed_reg;
    logic [SEED_W-1:0]   quo_reg;
    logic [DEN_W:0]      rem_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic                spawn_reg;
    logic [NUM_W-1:0]    decay_reg;
    logic [MOD_Q_W-1:0]  mod_q_reg;

    // store sweep and read data
    logic [AW-1:0]       clr_addr_reg;
    logic [COLOR_W-1:0]  rd_data_reg;
    logic [COLOR_W-1:0]  level_mem [MAX_PIXELS];

    // result register
    logic                out_valid_reg;
    logic [COLOR_W-1:0]  red_out_reg;
    logic [COLOR_W-1:0]  green_out_reg;
    logic [COLOR_W-1:0]  blue_out_reg;
    logic [COLOR_W-1:0]  level_out_reg;

    // combinational helpers
    logic                in_accept;
    logic                out_free;
    logic [XW-1:0]       idx_ext;
    logic [AW-1:0]       in_addr;
    logic [STEP_W-1:0]   dt_next;
    logic [DENS_W-1:0]   dens_sat;
    logic [DMS_W-1:0]    dms_eff;
    logic [THRESH_W-1:0] thresh_next;
    logic [SEED_W-1:0]   seed_next;
    logic [NUM_W-1:0]    num_next;
    logic [DEN_W:0]      den_ext;
    logic [DEN_W:0]      rem_shift;
    logic                quo_bit;
    logic [DEN_W:0]      rem_next;
    logic [SEED_W-1:0]   quo_next;
    logic [NUM_W-1:0]    quotient;
    logic [MOD_X_W-1:0]  mod_x;
    logic [MOD_PROD_W-1:0] recip_prod;
    logic [MOD_X_W-1:0]  mod_qd;
    logic [MOD_R_W-1:0]  mod_r;
    logic [THRESH_W-1:0] spawn_rem;
    logic [NUM_W-1:0]    rd_ext;
    logic [COLOR_W-1:0]  lv_next;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [COLOR_W-1:0]  mem_wdata;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign idx_ext = XW'(pixel_index);
    assign in_addr = idx_ext[AW-1:0];

    // a long frame gap counts as a normal frame
    assign dt_next  = (step_ms > STEP_MAX) ? STEP_DEFAULT : step_ms;
    assign dens_sat = (density_reg > DENS_MAX) ? DENS_MAX : density_reg;
    assign dms_eff  = (decay_ms_reg == '0) ? DMS_W'(1) : decay_ms_reg;

    assign thresh_next = THRESH_W'(dens_sat) * THRESH_W'(dt_reg);
    assign seed_next   = seed_reg * LCG_MUL + LCG_ADD;

    // rounded decay: (510 * dt + dms) / (2 * dms)
    assign num_next = DECAY_SCALE * NUM_W'(dt_reg) + NUM_W'(dms_eff);

    // one restoring division step
    assign den_ext   = {1'b0, den_reg};
    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[SEED_W-1]};
    assign quo_bit   = (rem_shift >= den_ext);
    assign rem_next  = quo_bit ? (rem_shift - den_ext) : rem_shift;
    assign quo_next  = {quo_reg[SEED_W-2:0], quo_bit};
    assign quotient  = quo_next[NUM_W-1:0];

    // seed mod 20000: (seed >> 5) mod 625 on top, the low five bits as they are
    assign mod_x      = seed_reg[SEED_W-1:MOD_LO_W];
    assign recip_prod = MOD_PROD_W'(mod_x) * MOD_PROD_W'(MOD_RECIP);
    assign mod_qd     = MOD_X_W'(mod_q_reg) * MOD_X_W'(MOD_ODD);
    assign mod_r      = MOD_R_W'(mod_x - mod_qd);
    assign spawn_rem  = THRESH_W'({mod_r, seed_reg[MOD_LO_W-1:0]});

    // fade, then a spawn overrides to full
    assign rd_ext  = NUM_W'(rd_data_reg);
    assign lv_next = spawn_reg ? LEVEL_FULL
                   : ((rd_ext > decay_reg) ? COLOR_W'(rd_ext - decay_reg) : '0);

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_APPLY);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : lv_next;

    // level store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            rd_data_reg <= level_mem[in_addr];
        end
    end

    // sequencer, datapath registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            enable_reg    <= 1'b0;
            density_reg   <= DENS_RESET;
            decay_ms_reg  <= DMS_RESET;
            seed_reg      <= SEED_INIT;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
            in_range_reg  <= 1'b0;
            dt_reg        <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            pass_reg      <= 1'b0;
            level_reg     <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            cnt_reg       <= '0;
            thresh_reg    <= '0;
            spawn_reg     <= 1'b0;
            decay_reg     <= '0;
            mod_q_reg     <= '0;
            red_out_reg   <= '0;
            green_out_reg <= '0;
            blue_out_reg  <= '0;
            level_out_reg <= '0;
        end
        else
        begin
            // configuration is to be written only while idle; the block does not enforce it
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:   enable_reg   <= cfg_data[0];
                    REG_DENSITY:  density_reg  <= cfg_data[DENS_W-1:0];
                    REG_DECAY_MS: decay_ms_reg <= cfg_data[DMS_W-1:0];
                    default:      ;
                endcase
            end

            // a taken result clears the register unless the next one lands now
            if (out_valid_reg && !out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(MAX_PIXELS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        addr_reg     <= in_addr;
                        in_range_reg <= (idx_ext < XW'(MAX_PIXELS));
                        dt_reg       <= dt_next;
                        red_reg      <= red_in;
                        green_reg    <= green_in;
                        blue_reg     <= blue_in;
                        state_reg    <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    thresh_reg <= thresh_next;
                    if (!in_range_reg)
                    begin
                        pass_reg  <= 1'b1;
                        level_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else if (!enable_reg)
                    begin
                        pass_reg  <= 1'b1;
                        level_reg <= rd_data_reg;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        pass_reg  <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    // advance the generator
                    seed_reg  <= seed_next;
                    state_reg <= ST_MOD_Q;
                end

                ST_MOD_Q:
                begin
                    // quotient of the upper seed bits by 625
                    mod_q_reg <= recip_prod[MOD_RECIP_SH +: MOD_Q_W];
                    state_reg <= ST_MOD_R;
                end

                ST_MOD_R:
                begin
                    spawn_reg <= (spawn_rem < thresh_reg);
                    // load the divider for the decay step, numerator left aligned
                    quo_reg   <= {num_next, {(SEED_W - NUM_W){1'b0}}};
                    rem_reg   <= '0;
                    den_reg   <= {dms_eff, 1'b0};
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= ST_DEC_RUN;
                end

                ST_DEC_RUN:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        // minimum fade of one per frame
                        decay_reg <= (quotient == '0) ? NUM_W'(1) : quotient;
                        state_reg <= ST_APPLY;
                    end
                end

                ST_APPLY:
                begin
                    // store write happens this cycle
                    level_reg <= lv_next;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        level_out_reg <= level_reg;
                        if (pass_reg)
                        begin
                            red_out_reg   <= red_reg;
                            green_out_reg <= green_reg;
                            blue_out_reg  <= blue_reg;
                        end
                        else
                        begin
                            red_out_reg   <= (red_reg > level_reg) ? red_reg : level_reg;
                            green_out_reg <= (green_reg > level_reg) ? green_reg : level_reg;
                            blue_out_reg  <= (blue_reg > level_reg) ? blue_reg : level_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_out       = red_out_reg;
    assign green_out     = green_out_reg;
    assign blue_out      = blue_out_reg;
    assign sparkle_level = level_out_reg;

    // the partial remainder never reaches the divisor while the divider runs
    `PSO_ASSERT_IMP(a_rem_below_den, state_reg == ST_DEC_RUN, rem_reg < den_ext)
    // the spawn remainder stays below the modulus
    `PSO_ASSERT_IMP(a_spawn_rem_range, state_reg == ST_MOD_R, spawn_rem < THRESH_W'(SPAWN_MOD))
    // the generator moves only in its own step
    `PSO_ASSERT_NEXT(a_seed_only_in_mul, state_reg != ST_MUL, $stable(seed_reg))
    // an accepted item always goes to the store check first
    `PSO_ASSERT_NEXT(a_accept_to_check, in_valid && !in_stall, state_reg == ST_CHECK)

endmodule

FILE: bench/tb_pixel_sparkle_overlay.sv
// self-checking testbench for the pixel sparkle overlay block
`timescale 1ns / 1ps

module tb_pixel_sparkle_overlay;

    import pso_pkg::*;

    // ---------------------------------------------------------------- constants

    localparam int unsigned STORE_DEPTH   = 512;        // matches the block default
    localparam bit [31:0]   SEED_START    = 32'd2463534242;
    localparam bit [31:0]   SEED_MUL      = 32'd1664525;
    localparam bit [31:0]   SEED_ADD      = 32'd1013904223;
    localparam int unsigned SPAWN_MODULUS = 20000;
    localparam int unsigned LONG_STEP     = 1000;       // steps above this count as 20 ms
    localparam int unsigned LONG_STEP_SUB = 20;
    localparam int unsigned DENSITY_CAP   = 100;
    localparam int unsigned FULL_LEVEL    = 255;
    localparam int unsigned IDLE_PERCENT  = 24;         // idle cycles per hundred, each side
    localparam int unsigned LONG_HOLD     = 400;        // receiver hold-off in cycles
    localparam int unsigned END_SLACK     = 64;         // wait for stray results after draining
    localparam int unsigned MAX_REPORTS   = 40;
    localparam longint      TIMEOUT_NS    = 8_000_000;

    // ---------------------------------------------------------------- types

    // one input item as the block sees it
    typedef struct {
        bit [IDX_W-1:0]   index;
        bit [STEP_W-1:0]  step;
        bit [COLOR_W-1:0] red;
        bit [COLOR_W-1:0] green;
        bit [COLOR_W-1:0] blue;
    } pixel_item_t;

    // one result item
    typedef struct {
        bit [COLOR_W-1:0] red;
        bit [COLOR_W-1:0] green;
        bit [COLOR_W-1:0] blue;
        bit [COLOR_W-1:0] level;
    } overlay_result_t;

    // ---------------------------------------------------------------- signals

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     pixel_index;
    logic [STEP_W-1:0]    step_ms;
    logic [COLOR_W-1:0]   red_in;
    logic [COLOR_W-1:0]   green_in;
    logic [COLOR_W-1:0]   blue_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [COLOR_W-1:0]   red_out;
    logic [COLOR_W-1:0]   green_out;
    logic [COLOR_W-1:0]   blue_out;
    logic [COLOR_W-1:0]   sparkle_level;

    // ---------------------------------------------------------------- bench state

    // shadow of the block: level store, generator and registers
    bit [COLOR_W-1:0] sparkle_store [STORE_DEPTH];
    bit [31:0]        noise_seed;
    bit               fx_enable;
    bit [DENS_W-1:0]  fx_density;
    bit [DMS_W-1:0]   fx_decay;

    pixel_item_t      pixel_feed[$];        // items waiting to be offered
    overlay_result_t  expected_pixels[$];   // predicted results, oldest first
    pixel_item_t      offered;              // item currently on the input port
    bit               offering;             // offered item not yet accepted
    bit               steady_run;           // no idling on either side while set
    int unsigned      hold_requests;        // long receiver hold-offs asked for
    int unsigned      holds_served;
    int unsigned      mismatches;
    int unsigned      results_seen;

    // ---------------------------------------------------------------- block

    pixel_sparkle_overlay dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel_index   (pixel_index),
        .step_ms       (step_ms),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .sparkle_level (sparkle_level)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    // one accepted pixel: fade its level, roll the generator, maybe spawn, overlay
    function automatic overlay_result_t overlay_pixel(input pixel_item_t item);
        overlay_result_t res;
        int unsigned     dt;
        int unsigned     dens;
        int unsigned     dms;
        int unsigned     fade;
        int unsigned     thresh;
        int unsigned     lv;
        res.red   = item.red;
        res.green = item.green;
        res.blue  = item.blue;
        // index past the store: plain pass-through with level zero
        if (item.index >= STORE_DEPTH) begin
            res.level = '0;
            return res;
        end
        // disabled: pass-through showing the stored level, nothing moves
        if (!fx_enable) begin
            res.level = sparkle_store[item.index];
            return res;
        end
        dt     = (item.step > LONG_STEP) ? LONG_STEP_SUB : item.step;
        dens   = (fx_density > DENSITY_CAP) ? DENSITY_CAP : fx_density;
        dms    = (fx_decay == 0) ? 1 : fx_decay;
        // round half up, never below one
        fade   = (2 * FULL_LEVEL * dt + dms) / (2 * dms);
        if (fade < 1)
            fade = 1;
        thresh = dens * dt;
        lv     = sparkle_store[item.index];
        lv     = (lv > fade) ? lv - fade : 0;
        noise_seed = noise_seed * SEED_MUL + SEED_ADD;
        if (noise_seed % SPAWN_MODULUS < thresh)
            lv = FULL_LEVEL;
        sparkle_store[item.index] = lv[COLOR_W-1:0];
        res.red   = (item.red   > lv) ? item.red   : lv[COLOR_W-1:0];
        res.green = (item.green > lv) ? item.green : lv[COLOR_W-1:0];
        res.blue  = (item.blue  > lv) ? item.blue  : lv[COLOR_W-1:0];
        res.level = lv[COLOR_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- shared tasks

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
    endtask

    // queue one item for the input driver
    task automatic send_pixel(input bit [IDX_W-1:0] index, input bit [STEP_W-1:0] step,
                              input bit [COLOR_W-1:0] red, input bit [COLOR_W-1:0] green,
                              input bit [COLOR_W-1:0] blue);
        pixel_item_t item;
        item.index = index;
        item.step  = step;
        item.red   = red;
        item.green = green;
        item.blue  = blue;
        pixel_feed.push_back(item);
    endtask

    // register write while the block is idle, shadow updated at the same edge
    task automatic write_reg(input cfg_reg_t which, input bit [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        case (which)
            REG_ENABLE:   fx_enable  = value[0];
            REG_DENSITY:  fx_density = value[DENS_W-1:0];
            REG_DECAY_MS: fx_decay   = value[DMS_W-1:0];
            default:      ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_effect(input bit en, input bit [DENS_W-1:0] dens,
                              input bit [DMS_W-1:0] decay);
        write_reg(REG_ENABLE, CFG_W'(en));
        write_reg(REG_DENSITY, CFG_W'(dens));
        write_reg(REG_DECAY_MS, CFG_W'(decay));
    endtask

    // every queued item accepted and every prediction matched by a result
    task automatic wait_drained();
        while (pixel_feed.size() != 0 || offering || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // random color channel, leaning on the extremes now and then
    function automatic bit [COLOR_W-1:0] random_channel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        return COLOR_W'($urandom_range(255));
    endfunction

    // mostly revisits a small window of pixels so levels build up and fade
    task automatic send_random_pixel(input int unsigned base);
        bit [IDX_W-1:0]  index;
        bit [STEP_W-1:0] step;
        int unsigned     pick;
        if ($urandom_range(99) < 75)
            index = IDX_W'(base + $urandom_range(7));
        else
            index = IDX_W'($urandom_range(STORE_DEPTH - 1));
        pick = $urandom_range(99);
        if (pick < 60)
            step = STEP_W'($urandom_range(120, 1));
        else if (pick < 75)
            step = STEP_W'($urandom_range(LONG_STEP, 121));
        else if (pick < 85)
            step = STEP_W'($urandom_range(1023, LONG_STEP + 1));
        else if (pick < 90)
            step = '0;
        else
            step = STEP_W'($urandom_range(1023));
        send_pixel(index, step, random_channel(), random_channel(), random_channel());
    endtask

    task automatic run_phase(input bit en, input bit [DENS_W-1:0] dens,
                             input bit [DMS_W-1:0] decay, input int unsigned count);
        int unsigned base;
        wait_drained();
        set_effect(en, dens, decay);
        base = $urandom_range(STORE_DEPTH - 8);
        repeat (count)
            send_random_pixel(base);
    endtask

    // ---------------------------------------------------------------- tests

    // reset values: disabled pass-through, then default density and decay
    task automatic test_reset_defaults();
        send_pixel(0, 0, 8'h00, 8'h00, 8'h00);
        send_pixel(511, 1023, 8'hff, 8'hff, 8'hff);
        wait_drained();
        write_reg(REG_ENABLE, CFG_W'(1));
        send_pixel(0, 0, 8'h00, 8'h00, 8'h00);
        send_pixel(511, 1023, 8'h12, 8'h34, 8'h56);
        send_pixel(256, 1001, 8'h80, 8'h7f, 8'h01);
        send_pixel(256, 1000, 8'h01, 8'h80, 8'hfe);
        wait_drained();
    endtask

    // saturated density, zero and largest decay, zero density, disabled readout
    task automatic test_directed_corners();
        // density above the cap with zero decay time: full threshold at step 200
        set_effect(1'b1, 7'd127, 16'd0);
        send_pixel(3, 200, 8'h55, 8'haa, 8'h00);
        send_pixel(3, 1, 8'h00, 8'hff, 8'h10);
        send_pixel(3, 1000, 8'h20, 8'h00, 8'hff);
        wait_drained();
        // slowest fade: minimum step of one, zero step spawns nothing
        set_effect(1'b1, 7'd100, 16'hffff);
        send_pixel(7, 200, 8'hff, 8'h80, 8'h01);
        send_pixel(7, 1, 8'h00, 8'h00, 8'h00);
        send_pixel(7, 0, 8'hfe, 8'h7f, 8'h00);
        wait_drained();
        // no spawning at all, long step fades the level
        write_reg(REG_DENSITY, CFG_W'(0));
        send_pixel(7, 1000, 8'h00, 8'h00, 8'h00);
        wait_drained();
        // disabled: stored levels show up, nothing changes
        write_reg(REG_ENABLE, CFG_W'(0));
        send_pixel(7, 500, 8'h01, 8'h02, 8'h03);
        send_pixel(3, 1023, 8'hff, 8'h00, 8'h80);
        wait_drained();
        // fastest fade: one ms clears a full level
        set_effect(1'b1, 7'd100, 16'd1);
        send_pixel(3, 1, 8'h40, 8'h40, 8'h40);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, the block backs up
    task automatic test_receiver_hold();
        wait_drained();
        set_effect(1'b1, 7'd60, 16'd200);
        hold_requests++;
        repeat (16)
            send_random_pixel(40);
        wait_drained();
    endtask

    // sender stops until every result is back, then resumes on warm state
    task automatic test_pause_until_drained();
        set_effect(1'b1, 7'd90, 16'd300);
        repeat (20)
            send_random_pixel(100);
        wait_drained();
        repeat (20)
            send_random_pixel(100);
        wait_drained();
    endtask

    // random traffic over a range of settings, one stretch with no idling
    task automatic test_random_traffic();
        run_phase(1'b1, 7'd100, 16'd400, 90);
        run_phase(1'b1, 7'd30, 16'd50, 90);
        wait_drained();
        steady_run = 1'b1;
        run_phase(1'b1, 7'd127, 16'd0, 90);
        wait_drained();
        steady_run = 1'b0;
        run_phase(1'b0, 7'd64, 16'd1000, 60);
        run_phase(1'b1, 7'd0, 16'hffff, 80);
        run_phase(1'b1, 7'd101, 16'd1, 80);
        run_phase(1'b1, DENS_W'($urandom_range(127)), DMS_W'($urandom_range(65535)), 80);
        wait_drained();
    endtask

    // ---------------------------------------------------------------- input driver

    // offers queued items, predicts each one at its accepting edge
    initial begin : pixel_driver
        in_valid    = 1'b0;
        pixel_index = '0;
        step_ms     = '0;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        offering    = 1'b0;
        forever begin
            @(posedge clk);
            if (in_valid && !in_stall) begin
                expected_pixels.push_back(overlay_pixel(offered));
                offering = 1'b0;
            end
            // random idle cycles before the next item, payload held while stalled
            if (!offering && pixel_feed.size() != 0 &&
                (steady_run || $urandom_range(99) >= IDLE_PERCENT)) begin
                offered     = pixel_feed.pop_front();
                offering    = 1'b1;
                in_valid    <= 1'b1;
                pixel_index <= offered.index;
                step_ms     <= offered.step;
                red_in      <= offered.red;
                green_in    <= offered.green;
                blue_in     <= offered.blue;
            end else if (!offering) begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver stall

    // random stalls, plus a counted hold-off whenever one is requested
    initial begin : result_stall
        int unsigned hold_left;
        out_stall    = 1'b0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !steady_run && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // ---------------------------------------------------------------- result checker

    // each accepted result against the oldest prediction, field by field
    initial begin : result_checker
        overlay_result_t want;
        results_seen = 0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with nothing expected, red", red_out, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (red_out !== want.red)
                        report_mismatch("red_out", red_out, want.red);
                    if (green_out !== want.green)
                        report_mismatch("green_out", green_out, want.green);
                    if (blue_out !== want.blue)
                        report_mismatch("blue_out", blue_out, want.blue);
                    if (sparkle_level !== want.level)
                        report_mismatch("sparkle_level", sparkle_level, want.level);
                end
                results_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_pixel_sparkle_overlay NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- test sequence

    initial begin : run_tests
        // shadow starts from the reset state of the block
        foreach (sparkle_store[i])
            sparkle_store[i] = '0;
        noise_seed    = SEED_START;
        fx_enable     = 1'b0;
        fx_density    = 7'd10;
        fx_decay      = 16'd400;
        steady_run    = 1'b0;
        hold_requests = 0;
        mismatches    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ENABLE;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_corners();
        test_receiver_hold();
        test_pause_until_drained();
        test_random_traffic();

        // any stray result after the last one shows up in the checker
        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (mismatches == 0)
            $display("tb_pixel_sparkle_overlay OK");
        else
            $display("tb_pixel_sparkle_overlay NOT OK");
        $finish;
    end

endmodule
